/* hdl/haar2d_pkg.sv */
package haar2d_pkg;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int POS_W    = 10;
    localparam int CFG_W    = 10;
    localparam int CFG_AW   = 1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam logic [CFG_AW-1:0] CFG_HALF_ROWS = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_HALF_COLS = 1'b1;

    localparam logic [CFG_W-1:0] HALF_ROWS_RST = 10'd256;
    localparam logic [CFG_W-1:0] HALF_COLS_RST = 10'd256;

    // subband order in which the four coefficients of a block leave
    typedef enum logic [1:0] {
        BAND_LL,
        BAND_HL,
        BAND_LH,
        BAND_HH
    } t_band;

endpackage

/* hdl/haar_2d_forward_one_level_core.sv */
// One level of the forward 2D Haar transform over a raster-order image of
// 2*half_rows by 2*half_cols samples. Each 2x2 block gives four coefficients
// (LL, HL, LH, HH, times two, exact) in that order, tagged with row and column
// of the quadrant layout; tuser marks the fourth beat of a block and tlast the
// last beat of the image. Samples of even rows are taken one per cycle unless
// held behind a pending block, and written to a single line memory (one write
// and one registered read port). In odd rows each pair of samples yields four
// output beats through one output register; a new block waits in the first
// stage until the previous one has left. Over a frame there is one beat out
// per sample. The completing sample of a block passes through the first stage
// and the output register before its first coefficient leaves. The line
// memory needs no clearing after reset. Write configuration only while idle.
module haar_2d_forward_one_level_core
    import haar2d_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [17:0] coefficient, [27:18] out_row,
                                                  // [37:28] out_col, [39:38] zero
    output logic                  m_axis_tuser,   // [0] group_last
    output logic                  m_axis_tlast    // frame_last
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int MW1   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int PW    = ((MW1 > CFG_W) ? MW1 : CFG_W) + 1;
    localparam logic [PW-1:0] LIM_R = PW'(MAX_ROWS / 2);
    localparam logic [PW-1:0] LIM_C = PW'(MAX_COLS / 2);

    // configuration
    logic [CFG_W-1:0] r_half_rows;
    logic [CFG_W-1:0] r_half_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_rows <= HALF_ROWS_RST;
            r_half_cols <= HALF_COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_HALF_ROWS: r_half_rows <= i_cfg_data;
                CFG_HALF_COLS: r_half_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [PW-1:0] hr_raw, hc_raw, hr, hc, height, width;

    always_comb begin
        hr_raw = PW'(r_half_rows);
        hc_raw = PW'(r_half_cols);
        if (hr_raw == '0)        hr = PW'(1);
        else if (hr_raw > LIM_R) hr = LIM_R;
        else                     hr = hr_raw;
        if (hc_raw == '0)        hc = PW'(1);
        else if (hc_raw > LIM_C) hc = LIM_C;
        else                     hc = hc_raw;
        height = hr << 1;
        width  = hc << 1;
    end

    // raster position
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [PW-1:0]    row_nx, col_nx;
    logic             row_wrap, col_wrap;
    logic             in_acc;

    assign row_nx   = PW'(r_row) + PW'(1);
    assign col_nx   = PW'(r_col) + PW'(1);
    assign row_wrap = (row_nx >= height);
    assign col_wrap = (col_nx >= width);
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_acc) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : row_nx[ROW_W-1:0];
            end else begin
                r_col <= col_nx[COL_W-1:0];
            end
        end
    end

    // first stage: beat accepted, line read data lines up with it
    logic                       r_s1_v;
    logic                       r_s1_blk;
    logic                       r_s1_cap;
    logic signed [SAMPLE_W-1:0] r_s1_d;
    logic [PW-1:0]              r_s1_i;
    logic [PW-1:0]              r_s1_j;
    logic                       r_s1_fl;
    logic [COL_W-1:0]           r_s1_col;
    logic                       s1_adv;
    logic                       emit_free;

    assign s1_adv        = !r_s1_v || !r_s1_blk || emit_free;
    assign s_axis_tready = s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_adv) begin
            r_s1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_blk <= r_row[0] && r_col[0];
            r_s1_cap <= r_row[0] && !r_col[0];
            r_s1_d   <= s_axis_tdata[SAMPLE_W-1:0];
            r_s1_i   <= PW'(r_row >> 1);
            r_s1_j   <= PW'(r_col >> 1);
            r_s1_fl  <= row_wrap && col_wrap;
            r_s1_col <= r_col;
        end
    end

    // line memory: even rows write, odd rows read; a read of an entry always
    // trails its write by at least one full row, so no forwarding is needed
    logic [SAMPLE_W-1:0] line_mem [MAX_COLS];
    logic [SAMPLE_W-1:0] r_rdata;
    logic [COL_W-1:0]    rd_addr;

    // hold the read on the stalled beat so its data stays aligned
    assign rd_addr = s1_adv ? r_col : r_s1_col;

    always_ff @(posedge i_clk) begin
        if (in_acc && !r_row[0]) begin
            line_mem[r_col] <= s_axis_tdata[SAMPLE_W-1:0];
        end
        r_rdata <= line_mem[rd_addr];
    end

    // left sample of the odd row and upper-left sample of the block
    logic signed [SAMPLE_W-1:0] r_held;
    logic signed [SAMPLE_W-1:0] r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (in_acc && r_row[0] && !r_col[0]) begin
            r_held <= s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v && r_s1_cap) begin
            r_a <= r_rdata;
        end
    end

    // butterflies
    logic signed [COEF_W-1:0] xa, xb, xc, xd;
    logic signed [COEF_W-1:0] s_ab, d_ab, s_cd, d_cd;
    logic [PW-1:0]            row_hi, col_hi;

    always_comb begin
        xa     = COEF_W'(r_a);
        xb     = COEF_W'($signed(r_rdata));
        xc     = COEF_W'(r_held);
        xd     = COEF_W'(r_s1_d);
        s_ab   = xa + xb;
        d_ab   = xa - xb;
        s_cd   = xc + xd;
        d_cd   = xc - xd;
        row_hi = r_s1_i + hr;
        col_hi = r_s1_j + hc;
    end

    // output register holding one block, sent as four beats
    logic                     r_ov;
    t_band                    r_band;
    logic signed [COEF_W-1:0] r_ll, r_hl, r_lh, r_hh;
    logic [POS_W-1:0]         r_row_lo, r_row_hi, r_col_lo, r_col_hi;
    logic                     r_fl;
    logic                     load;

    assign emit_free = !r_ov || (r_band == BAND_HH && m_axis_tready);
    assign load      = r_s1_v && r_s1_blk && emit_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_band <= BAND_LL;
        end else if (load) begin
            r_ov   <= 1'b1;
            r_band <= BAND_LL;
        end else if (r_ov && m_axis_tready) begin
            if (r_band == BAND_HH) begin
                r_ov <= 1'b0;
            end else begin
                r_band <= t_band'(r_band + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ll     <= s_ab + s_cd;
            r_hl     <= d_ab + d_cd;
            r_lh     <= s_ab - s_cd;
            r_hh     <= d_ab - d_cd;
            r_row_lo <= r_s1_i[POS_W-1:0];
            r_row_hi <= row_hi[POS_W-1:0];
            r_col_lo <= r_s1_j[POS_W-1:0];
            r_col_hi <= col_hi[POS_W-1:0];
            r_fl     <= r_s1_fl;
        end
    end

    logic signed [COEF_W-1:0] o_coef;
    logic [POS_W-1:0]         o_row, o_col;

    always_comb begin
        unique case (r_band)
            BAND_LL: begin
                o_coef = r_ll;
                o_row  = r_row_lo;
                o_col  = r_col_lo;
            end
            BAND_HL: begin
                o_coef = r_hl;
                o_row  = r_row_lo;
                o_col  = r_col_hi;
            end
            BAND_LH: begin
                o_coef = r_lh;
                o_row  = r_row_hi;
                o_col  = r_col_lo;
            end
            default: begin
                o_coef = r_hh;
                o_row  = r_row_hi;
                o_col  = r_col_hi;
            end
        endcase
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {2'b00, o_col, o_row, o_coef};
    assign m_axis_tuser  = (r_band == BAND_HH);
    assign m_axis_tlast  = (r_band == BAND_HH) && r_fl;

endmodule

/* hdl/haar2d_chk.sv */
module haar2d_chk
    import haar2d_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);

    // a stalled output beat keeps its content
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(m_axis_tvalid && !m_axis_tready)
        |-> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // end of image only on the closing beat of a block
    a_last_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("frame end outside a block end");

    // input stalls only behind a pending output beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output pending");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind haar_2d_forward_one_level_core haar2d_chk u_haar2d_chk (.*);
